[sv/utf8sd_pkg.sv]
// shared types, constants and helpers for the strict utf-8 decoder
`timescale 1ns / 1ps

package utf8sd_pkg;

  localparam int CP_W  = 21;
  localparam int CNT_W = 3;
  localparam int OUT_DATA_W = 24;

  localparam logic [7:0] LEAD2_LO = 8'hC2;
  localparam logic [7:0] LEAD2_HI = 8'hDF;
  localparam logic [7:0] LEAD3_LO = 8'hE0;
  localparam logic [7:0] LEAD3_HI = 8'hEF;
  localparam logic [7:0] LEAD4_LO = 8'hF0;
  localparam logic [7:0] LEAD4_HI = 8'hF4;

  localparam logic [7:0] E0_SECOND_MIN = 8'hA0;
  localparam logic [7:0] ED_LEAD       = 8'hED;
  localparam logic [7:0] ED_SECOND_MAX = 8'h9F;
  localparam logic [7:0] F0_SECOND_MIN = 8'h90;
  localparam logic [7:0] F4_SECOND_MAX = 8'h8F;

  localparam logic [1:0] CONT_TAG = 2'b10;

  localparam logic [CNT_W-1:0] LEN1 = 3'd1;
  localparam logic [CNT_W-1:0] LEN2 = 3'd2;
  localparam logic [CNT_W-1:0] LEN3 = 3'd3;
  localparam logic [CNT_W-1:0] LEN4 = 3'd4;

  typedef struct packed {
    logic             string_end;
    logic             error;
    logic [CNT_W-1:0] byte_count;
    logic [CP_W-1:0]  code_point;
  } result_t;

  // second byte limits after the special lead bytes
  function automatic logic second_bad(input logic [7:0] lead, input logic [7:0] b);
    logic bad;
    bad = 1'b0;
    if (lead == LEAD3_LO && b < E0_SECOND_MIN) bad = 1'b1;
    if (lead == ED_LEAD && b > ED_SECOND_MAX) bad = 1'b1;
    if (lead == LEAD4_LO && b < F0_SECOND_MIN) bad = 1'b1;
    if (lead == LEAD4_HI && b > F4_SECOND_MAX) bad = 1'b1;
    return bad;
  endfunction

endpackage

[sv/utf8_strict_decoder.sv]
// a completed result is registered in the output register, or in the skid entry on a stall
// throughput: one byte per cycle while s_axis_tready is high; decode work is one pass of logic on the sequence state
// a two-entry output stage (register plus skid) keeps input flowing while a result waits
// s_axis_tready drops only while the skid entry is occupied
// rst (synchronous, active high) clears the sequence state and empties the output stage
`timescale 1ns / 1ps

module utf8_strict_decoder
  import utf8sd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // in_byte
  input  logic                  s_axis_tlast,   // string_last
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // code_point [20:0], byte_count [23:21]
  output logic                  m_axis_tuser,   // error
  output logic                  m_axis_tlast    // string_end
);

  logic [1:0]       pending, pending_next;
  logic [CNT_W-1:0] seq_len, seq_len_next;
  logic [CP_W-1:0]  partial, partial_next;
  logic [7:0]       lead, lead_next;
  logic             second_seen, second_seen_next;
  logic             discarding, discarding_next;

  logic    res_valid;
  result_t res;
  logic    accept;
  logic    res_fire;

  logic    out_valid;
  result_t out_res;
  logic    skid_valid;
  result_t skid_res;

  logic [7:0] b;
  logic       last;
  logic       fail;
  logic       clear;
  logic [CP_W-1:0] shifted;

  assign b    = s_axis_tdata;
  assign last = s_axis_tlast;
  assign shifted = {partial[CP_W-7:0], b[5:0]};

  always_comb begin
    res              = '0;
    res_valid        = 1'b0;
    fail             = 1'b0;
    clear            = 1'b0;
    pending_next     = pending;
    seq_len_next     = seq_len;
    partial_next     = partial;
    lead_next        = lead;
    second_seen_next = second_seen;
    discarding_next  = discarding;

    if (discarding) begin
      if (last) begin
        res_valid      = 1'b1;
        res.string_end = 1'b1;
        clear          = 1'b1;
      end
    end else if (pending == 2'd0) begin
      if (!b[7]) begin
        res_valid      = 1'b1;
        res.code_point = {{(CP_W-8){1'b0}}, b};
        res.byte_count = LEN1;
        res.string_end = last;
        clear          = 1'b1;
      end else begin
        unique case (b) inside
          [LEAD2_LO:LEAD2_HI]: begin
            seq_len_next = LEN2;
            pending_next = 2'd1;
            partial_next = {{(CP_W-5){1'b0}}, b[4:0]};
          end
          [LEAD3_LO:LEAD3_HI]: begin
            seq_len_next = LEN3;
            pending_next = 2'd2;
            partial_next = {{(CP_W-4){1'b0}}, b[3:0]};
          end
          [LEAD4_LO:LEAD4_HI]: begin
            seq_len_next = LEN4;
            pending_next = 2'd3;
            partial_next = {{(CP_W-3){1'b0}}, b[2:0]};
          end
          default: fail = 1'b1;
        endcase
        if (last) fail = 1'b1;
        lead_next        = b;
        second_seen_next = 1'b0;
      end
    end else begin
      if (b[7:6] != CONT_TAG || (!second_seen && second_bad(lead, b))) begin
        fail = 1'b1;
      end else begin
        partial_next     = shifted;
        pending_next     = pending - 2'd1;
        second_seen_next = 1'b1;
        if (pending == 2'd1) begin
          res_valid      = 1'b1;
          res.code_point = shifted;
          res.byte_count = seq_len;
          res.string_end = last;
          clear          = 1'b1;
        end else if (last) begin
          fail = 1'b1;
        end
      end
    end

    if (fail) begin
      res_valid       = 1'b1;
      res             = '0;
      res.error       = 1'b1;
      res.string_end  = last;
      clear           = 1'b1;
    end

    if (clear) begin
      pending_next     = 2'd0;
      seq_len_next     = '0;
      partial_next     = '0;
      lead_next        = '0;
      second_seen_next = 1'b0;
      discarding_next  = fail && !last;
    end
  end

  assign s_axis_tready = !skid_valid;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign res_fire      = accept && res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending     <= 2'd0;
      seq_len     <= '0;
      partial     <= '0;
      lead        <= '0;
      second_seen <= 1'b0;
      discarding  <= 1'b0;
    end else if (accept) begin
      pending     <= pending_next;
      seq_len     <= seq_len_next;
      partial     <= partial_next;
      lead        <= lead_next;
      second_seen <= second_seen_next;
      discarding  <= discarding_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_axis_tready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_fire;
      end
    end else if (res_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_axis_tready || !out_valid) begin
      out_res <= skid_valid ? skid_res : res;
    end else if (res_fire) begin
      skid_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_res.byte_count, out_res.code_point};
  assign m_axis_tuser  = out_res.error;
  assign m_axis_tlast  = out_res.string_end;

endmodule

[sv/utf8sd_checker.sv]
// port-level checks for the strict utf-8 decoder and their binding
`timescale 1ns / 1ps

module utf8sd_checker
  import utf8sd_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tuser,
  input logic                  m_axis_tlast
);

  logic [CNT_W-1:0] cnt;
  assign cnt = m_axis_tdata[OUT_DATA_W-1:CP_W];

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // an error carries no code point and no count
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("error result with data");

  // a good result has a count from one to four, or is a bare end marker
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser && cnt == '0 |-> m_axis_tlast && m_axis_tdata == '0)
    else $error("zero count on a non-end result");

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |->
      cnt != 3'd5 && cnt != 3'd6 && cnt != 3'd7 && m_axis_tdata[CP_W-1:0] <= 21'h10FFFF)
    else $error("count or code point out of range");

  // a one-byte result is plain ascii
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser && cnt == LEN1 |-> m_axis_tdata[CP_W-1:7] == '0)
    else $error("one-byte result above ascii");

endmodule

bind utf8_strict_decoder utf8sd_checker u_utf8sd_checker (.*);

[tb/tb_utf8_strict_decoder.sv]
// self-checking testbench for the strict utf-8 decoder: directed table, random strings
`timescale 1ns / 1ps

module tb_utf8_strict_decoder;
  import utf8sd_pkg::*;

  localparam int RANDOM_BYTES = 950;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct {
    logic [7:0] b;
    logic       last;
    logic       typed;
    result_t    want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = 8'h00;   // in_byte
  logic                  s_axis_tlast = 1'b0;    // string_last
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;           // code_point [20:0], byte_count [23:21]
  logic                  m_axis_tuser;           // error
  logic                  m_axis_tlast;           // string_end

  // expectation attached to the byte currently offered
  logic    cur_typed = 1'b0;
  result_t cur_want  = '0;

  // decoder state mirror
  logic [1:0]       dec_pending;
  logic [CNT_W-1:0] dec_len;
  logic [CP_W-1:0]  dec_value;
  logic [7:0]       dec_lead;
  logic             dec_second;
  logic             dec_discard;

  result_t    result_q[$];
  stim_row_t  directed_q[$];
  logic [7:0] str_q[$];

  int cycles;
  int bytes_accepted;
  int fail_count;
  int results_checked;
  int error_results;
  int end_markers;
  int four_byte_results;
  int strings_sent;
  int burst_left;
  int pattern_left;
  int stall_phase;
  bit full_rate;
  logic [7:0] stall_mask;

  utf8_strict_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic result_t mk_result(input logic [CP_W-1:0] cp, input logic [CNT_W-1:0] cnt,
                                        input logic err, input logic fin);
    result_t r;
    r.code_point = cp;
    r.byte_count = cnt;
    r.error      = err;
    r.string_end = fin;
    return r;
  endfunction

  function automatic void dec_clear();
    dec_pending = '0;
    dec_len     = '0;
    dec_value   = '0;
    dec_lead    = '0;
    dec_second  = 1'b0;
    dec_discard = 1'b0;
  endfunction

  function automatic bit flag_error(input logic last, output result_t r);
    r = mk_result('0, '0, 1'b1, last);
    dec_clear();
    dec_discard = !last;
    return 1'b1;
  endfunction

  // returns 1 when the byte yields a result
  function automatic bit decode_step(input logic [7:0] b, input logic last, output result_t r);
    logic bad_second;
    r = '0;
    if (dec_discard) begin
      if (!last) return 1'b0;
      r = mk_result('0, '0, 1'b0, 1'b1);
      dec_clear();
      return 1'b1;
    end
    if (dec_pending == 2'd0) begin
      if (!b[7]) begin
        r = mk_result(CP_W'(b), LEN1, 1'b0, last);
        dec_clear();
        return 1'b1;
      end
      if (b >= LEAD2_LO && b <= LEAD2_HI) begin
        dec_len = LEN2;
        dec_value = CP_W'(b[4:0]);
      end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
        dec_len = LEN3;
        dec_value = CP_W'(b[3:0]);
      end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
        dec_len = LEN4;
        dec_value = CP_W'(b[2:0]);
      end else begin
        return flag_error(last, r);
      end
      if (last) return flag_error(last, r);
      dec_pending = 2'(dec_len - 3'd1);
      dec_lead = b;
      dec_second = 1'b0;
      return 1'b0;
    end
    if (b[7:6] != CONT_TAG) return flag_error(last, r);
    if (!dec_second) begin
      bad_second = (dec_lead == LEAD3_LO && b < E0_SECOND_MIN) ||
                   (dec_lead == ED_LEAD  && b > ED_SECOND_MAX) ||
                   (dec_lead == LEAD4_LO && b < F0_SECOND_MIN) ||
                   (dec_lead == LEAD4_HI && b > F4_SECOND_MAX);
      if (bad_second) return flag_error(last, r);
      dec_second = 1'b1;
    end
    dec_value = {dec_value[CP_W-7:0], b[5:0]};
    dec_pending = dec_pending - 2'd1;
    if (dec_pending == 2'd0) begin
      r = mk_result(dec_value, dec_len, 1'b0, last);
      dec_clear();
      return 1'b1;
    end
    if (last) return flag_error(last, r);
    return 1'b0;
  endfunction

  // transfer monitor on both sides
  always @(posedge clk) begin : monitor
    result_t want;
    result_t pred;
    bit got;
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $error("timeout: %0d results still outstanding", result_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (result_q.size() == 0) begin
          $error("unexpected result: tdata %h tuser %b tlast %b",
                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
          fail_count++;
        end else begin
          want = result_q.pop_front();
          results_checked++;
          if (want.error) error_results++;
          if (want.string_end) end_markers++;
          if (want.byte_count == LEN4) four_byte_results++;
          if (m_axis_tdata[CP_W-1:0] !== want.code_point) begin
            $error("code_point: expected %h, got %h", want.code_point,
                   m_axis_tdata[CP_W-1:0]);
            fail_count++;
          end
          if (m_axis_tdata[CP_W +: CNT_W] !== want.byte_count) begin
            $error("byte_count: expected %0d, got %0d", want.byte_count,
                   m_axis_tdata[CP_W +: CNT_W]);
            fail_count++;
          end
          if (m_axis_tuser !== want.error) begin
            $error("error: expected %b, got %b", want.error, m_axis_tuser);
            fail_count++;
          end
          if (m_axis_tlast !== want.string_end) begin
            $error("string_end: expected %b, got %b", want.string_end, m_axis_tlast);
            fail_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        bytes_accepted++;
        got = decode_step(s_axis_tdata, s_axis_tlast, pred);
        if (cur_typed) result_q = {result_q, cur_want};
        else if (got) result_q = {result_q, pred};
      end
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (pattern_left == 0) begin
      pattern_left = $urandom_range(20, 120);
      full_rate = ($urandom_range(0, 2) == 0);
      stall_mask = 8'($urandom_range(1, 255));
    end
    pattern_left--;
    stall_phase = (stall_phase + 1) % 8;
    m_axis_tready <= full_rate || stall_mask[stall_phase];
  end

  task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                           input result_t want);
    int target;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    target = bytes_accepted + 1;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    cur_typed     <= typed;
    cur_want      <= want;
    do @(negedge clk); while (bytes_accepted < target);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (result_q.size() != 0) @(negedge clk);
  endtask

  function automatic void add_row(input logic [7:0] b, input logic last, input logic typed,
                                  input logic [CP_W-1:0] cp, input logic [CNT_W-1:0] cnt,
                                  input logic err, input logic fin);
    stim_row_t row;
    row.b = b;
    row.last = last;
    row.typed = typed;
    row.want = mk_result(cp, cnt, err, fin);
    directed_q = {directed_q, row};
  endfunction

  // appends one byte to the string under construction
  function automatic void str_add(input logic [7:0] v);
    str_q = {str_q, v};
  endfunction

  // appends one well-formed scalar value of the given length to the string
  task automatic push_code_point(input int len);
    int lo;
    int hi;
    logic [CP_W-1:0] cp;
    case (len)
      1: begin lo = 0; hi = 'h7F; end
      2: begin lo = 'h80; hi = 'h7FF; end
      3: begin lo = 'h800; hi = 'hFFFF; end
      default: begin lo = 'h10000; hi = 'h10FFFF; end
    endcase
    if ($urandom_range(0, 5) == 0) cp = CP_W'($urandom_range(0, 1) ? lo : hi);
    else cp = CP_W'($urandom_range(lo, hi));
    if (len == 3 && cp >= 'hD800 && cp <= 'hDFFF) cp = cp ^ 21'h1000;
    case (len)
      1: str_add(cp[7:0]);
      2: begin
        str_add({3'b110, cp[10:6]});
        str_add({CONT_TAG, cp[5:0]});
      end
      3: begin
        str_add({4'b1110, cp[15:12]});
        str_add({CONT_TAG, cp[11:6]});
        str_add({CONT_TAG, cp[5:0]});
      end
      default: begin
        str_add({5'b11110, cp[20:18]});
        str_add({CONT_TAG, cp[17:12]});
        str_add({CONT_TAG, cp[11:6]});
        str_add({CONT_TAG, cp[5:0]});
      end
    endcase
  endtask

  initial begin : stimulus
    int n_tokens;
    int kind;
    int len;
    int idx;
    bit drained_mid;
    logic [7:0] lead;
    dec_clear();

    add_row(8'h00, 1'b1, 1'b1, 21'h0,      LEN1, 1'b0, 1'b1);
    add_row(8'h7F, 1'b0, 1'b1, 21'h7F,     LEN1, 1'b0, 1'b0);
    add_row(8'hC2, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
    add_row(8'h80, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
    add_row(8'hDF, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
    add_row(8'hBF, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
    // overlong three-byte form, then discard up to the end marker
    add_row(8'hE0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
    add_row(8'h9F, 1'b0, 1'b1, 21'h0,      '0,   1'b1, 1'b0);
    add_row(8'h42, 1'b1, 1'b1, 21'h0,      '0,   1'b0, 1'b1);
    // surrogate on the final byte
    add_row(8'hED, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
    add_row(8'hA0, 1'b1, 1'b1, 21'h0,      '0,   1'b1, 1'b1);
    // above the top scalar value
    add_row(8'hF4, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
    add_row(8'h90, 1'b1, 1'b1, 21'h0,      '0,   1'b1, 1'b1);
    add_row(8'hF0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
    add_row(8'h90, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
    add_row(8'h80, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
    add_row(8'h80, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
    add_row(8'hF4, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
    add_row(8'h8F, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
    add_row(8'hBF, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
    add_row(8'hBF, 1'b0, 1'b1, 21'h10FFFF, LEN4, 1'b0, 1'b0);
    // missing continuation byte
    add_row(8'hC3, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0);
    add_row(8'h41, 1'b0, 1'b1, 21'h0,      '0,   1'b1, 1'b0);
    add_row(8'hFF, 1'b1, 1'b1, 21'h0,      '0,   1'b0, 1'b1);
    // bad lead byte as the final byte
    add_row(8'h80, 1'b1, 1'b1, 21'h0,      '0,   1'b1, 1'b1);
    // lead byte cut off by the string end
    add_row(8'hE1, 1'b1, 1'b1, 21'h0,      '0,   1'b1, 1'b1);

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_q[i])
      send_byte(directed_q[i].b, directed_q[i].last, directed_q[i].typed, directed_q[i].want);
    drain();

    drained_mid = 1'b0;
    while (bytes_accepted < RANDOM_BYTES + directed_q.size()) begin
      str_q.delete();
      n_tokens = $urandom_range(1, 8);
      repeat (n_tokens) begin
        kind = $urandom_range(0, 99);
        len = $urandom_range(1, 4);
        if (kind < 75) begin
          push_code_point(len);
        end else if (kind < 83) begin
          // special lead bytes with any continuation as the second byte
          case ($urandom_range(0, 3))
            0: lead = LEAD3_LO;
            1: lead = ED_LEAD;
            2: lead = LEAD4_LO;
            default: lead = LEAD4_HI;
          endcase
          str_add(lead);
          str_add(8'($urandom_range(8'h80, 8'hBF)));
          repeat ((lead >= LEAD4_LO) ? 2 : 1) str_add(8'($urandom_range(8'h80, 8'hBF)));
        end else if (kind < 89) begin
          len = $urandom_range(2, 4);
          push_code_point(len);
          repeat ($urandom_range(1, len - 1)) void'(str_q.pop_back());
        end else if (kind < 94) begin
          len = $urandom_range(2, 4);
          push_code_point(len);
          idx = str_q.size() - $urandom_range(1, len - 1);
          str_q[idx] = $urandom_range(0, 1) ? 8'($urandom_range(0, 8'h7F))
                                            : 8'($urandom_range(8'hC0, 8'hFF));
        end else begin
          str_add(8'($urandom_range(0, 255)));
        end
      end
      foreach (str_q[i])
        send_byte(str_q[i], i == str_q.size() - 1, 1'b0, '0);
      strings_sent++;
      if (!drained_mid && bytes_accepted > RANDOM_BYTES / 2) begin
        drain();
        drained_mid = 1'b1;
      end
    end

    drain();
    repeat (20) @(negedge clk);
    $display("run: %0d bytes in %0d random strings plus the directed table",
             bytes_accepted, strings_sent);
    $display("results checked: %0d (%0d errors, %0d string ends, %0d four-byte values)",
             results_checked, error_results, end_markers, four_byte_results);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/utf8sd_pkg.sv
sv/utf8_strict_decoder.sv
sv/utf8sd_checker.sv
tb/tb_utf8_strict_decoder.sv
